// ----- hdl/divider_timer_with_reload_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the divider timer block.
// ----------------------------------------------------------------------------
`ifndef DIVIDER_TIMER_WITH_RELOAD_TOP_MACROS_SVH
`define DIVIDER_TIMER_WITH_RELOAD_TOP_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define DTR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define DTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/dtr_pkg.sv -----
// ----------------------------------------------------------------------------
// dtr_pkg
// Types and constants shared by the divider timer controller and datapath.
// ----------------------------------------------------------------------------
package dtr_pkg;

    localparam int unsigned IN_W  = 24;
    localparam int unsigned OUT_W = 16;

    localparam logic [7:0] CTRL_FORCED_ONES = 8'hF8;
    localparam int unsigned CTRL_START_BIT  = 2;
    localparam logic [8:0] DIV_RELOAD       = 9'd256;

    localparam int unsigned DIV_SEL0 = 4096;
    localparam int unsigned DIV_SEL1 = 262144;
    localparam int unsigned DIV_SEL2 = 65536;
    localparam int unsigned DIV_SEL3 = 16384;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_DIV  = 2'd0,
        REG_TIMA = 2'd1,
        REG_TMA  = 2'd2,
        REG_TAC  = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic accept;
        logic step;
        logic load_acc;
        logic load_step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic adv_loop;
        logic step_last;
    } t_dp_status;

endpackage

// ----- hdl/dtr_dpath.sv -----
// ----------------------------------------------------------------------------
// dtr_dpath
// Register file, divider and timer prescalers, timer step unit, result register.
// ----------------------------------------------------------------------------
module dtr_dpath #(
    parameter int unsigned CPU_CLOCK_HZ = 4194304
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dtr_pkg::t_ctrl_cmd     i_cmd,
    input  logic [1:0]             i_command,
    input  logic [1:0]             i_reg_offset,
    input  logic [7:0]             i_write_data,
    input  logic [7:0]             i_cycles,
    output dtr_pkg::t_dp_status    o_status,
    output logic [7:0]             o_read_data,
    output logic                   o_timer_interrupt
);

    `include "divider_timer_with_reload_top_macros.svh"

    localparam int unsigned RAW0 = CPU_CLOCK_HZ / dtr_pkg::DIV_SEL0;
    localparam int unsigned RAW1 = CPU_CLOCK_HZ / dtr_pkg::DIV_SEL1;
    localparam int unsigned RAW2 = CPU_CLOCK_HZ / dtr_pkg::DIV_SEL2;
    localparam int unsigned RAW3 = CPU_CLOCK_HZ / dtr_pkg::DIV_SEL3;
    localparam int unsigned P0   = (RAW0 == 0) ? 1 : RAW0;
    localparam int unsigned P1   = (RAW1 == 0) ? 1 : RAW1;
    localparam int unsigned P2   = (RAW2 == 0) ? 1 : RAW2;
    localparam int unsigned P3   = (RAW3 == 0) ? 1 : RAW3;
    localparam int unsigned TP_W = $clog2(P0 + 1);
    localparam int unsigned CW   = (TP_W > 8) ? TP_W : 8;

    function automatic logic [TP_W-1:0] f_period(input logic [1:0] sel);
        logic [TP_W-1:0] p;
        unique case (sel)
            2'd0:    p = TP_W'(P0);
            2'd1:    p = TP_W'(P1);
            2'd2:    p = TP_W'(P2);
            default: p = TP_W'(P3);
        endcase
        return p;
    endfunction

    logic [7:0]      r_div, n_div;
    logic [7:0]      r_tima, n_tima;
    logic [7:0]      r_tma, n_tma;
    logic [7:0]      r_tac, n_tac;
    logic [8:0]      r_dpre, n_dpre;
    logic [TP_W-1:0] r_tpre, n_tpre;
    logic [7:0]      r_remain, n_remain;
    logic            r_irq, n_irq;
    logic [7:0]      r_rd, n_rd;
    logic            r_out_irq, n_out_irq;

    dtr_pkg::t_cmd   w_cmd;
    dtr_pkg::t_reg   w_reg;
    logic [CW-1:0]   w_tpre;
    logic [CW-1:0]   w_rem;
    logic            w_tick;
    logic            w_wrap;
    logic [7:0]      w_rem_next;
    logic [8:0]      w_dpre_sub;
    logic [7:0]      w_rd_mux;

    assign w_cmd      = dtr_pkg::t_cmd'(i_command);
    assign w_reg      = dtr_pkg::t_reg'(i_reg_offset);
    assign w_tpre     = CW'(r_tpre);
    assign w_rem      = CW'(r_remain);
    assign w_tick     = (w_tpre <= w_rem);
    assign w_wrap     = w_tick && (r_tima == 8'hFF);
    assign w_rem_next = w_tick ? 8'(w_rem - w_tpre) : 8'd0;
    assign w_dpre_sub = (r_dpre > {1'b0, i_cycles}) ? (r_dpre - {1'b0, i_cycles}) : 9'd0;

    always_comb begin
        unique case (w_reg)
            dtr_pkg::REG_DIV:  w_rd_mux = r_div;
            dtr_pkg::REG_TIMA: w_rd_mux = r_tima;
            dtr_pkg::REG_TMA:  w_rd_mux = r_tma;
            dtr_pkg::REG_TAC:  w_rd_mux = r_tac;
        endcase
    end

    always_comb begin
        n_div     = r_div;
        n_tima    = r_tima;
        n_tma     = r_tma;
        n_tac     = r_tac;
        n_dpre    = r_dpre;
        n_tpre    = r_tpre;
        n_remain  = r_remain;
        n_irq     = r_irq;
        n_rd      = r_rd;
        n_out_irq = r_out_irq;

        if (i_cmd.accept) begin
            unique case (w_cmd)
                dtr_pkg::CMD_WRITE: begin
                    unique case (w_reg)
                        dtr_pkg::REG_DIV:  n_div = 8'd0;
                        dtr_pkg::REG_TIMA: n_tima = i_write_data;
                        dtr_pkg::REG_TMA:  n_tma = i_write_data;
                        dtr_pkg::REG_TAC: begin
                            n_tac  = i_write_data | dtr_pkg::CTRL_FORCED_ONES;
                            n_tpre = f_period(i_write_data[1:0]);
                        end
                    endcase
                end
                dtr_pkg::CMD_ADVANCE: begin
                    if (w_dpre_sub == 9'd0) begin
                        n_div  = r_div + 8'd1;
                        n_dpre = dtr_pkg::DIV_RELOAD;
                    end else begin
                        n_dpre = w_dpre_sub;
                    end
                    n_remain = i_cycles;
                    n_irq    = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.step) begin
            n_remain = w_rem_next;
            if (w_tick) begin
                n_tpre = f_period(r_tac[1:0]);
                if (w_wrap) begin
                    n_tima = r_tma;
                    n_irq  = 1'b1;
                end else begin
                    n_tima = r_tima + 8'd1;
                end
            end else begin
                n_tpre = TP_W'(w_tpre - w_rem);
            end
        end

        if (i_cmd.load_acc) begin
            n_rd      = (w_cmd == dtr_pkg::CMD_READ) ? w_rd_mux : 8'd0;
            n_out_irq = 1'b0;
        end else if (i_cmd.load_step) begin
            n_rd      = 8'd0;
            n_out_irq = n_irq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div    <= 8'd0;
            r_tima   <= 8'd0;
            r_tma    <= 8'd0;
            r_tac    <= 8'd0;
            r_dpre   <= 9'd0;
            r_tpre   <= '0;
            r_remain <= 8'd0;
            r_irq    <= 1'b0;
        end else begin
            r_div    <= n_div;
            r_tima   <= n_tima;
            r_tma    <= n_tma;
            r_tac    <= n_tac;
            r_dpre   <= n_dpre;
            r_tpre   <= n_tpre;
            r_remain <= n_remain;
            r_irq    <= n_irq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd      <= n_rd;
        r_out_irq <= n_out_irq;
    end

    assign o_status.adv_loop  = (w_cmd == dtr_pkg::CMD_ADVANCE)
                              && r_tac[dtr_pkg::CTRL_START_BIT] && (i_cycles != 8'd0);
    assign o_status.step_last = (w_rem_next == 8'd0);
    assign o_read_data        = r_rd;
    assign o_timer_interrupt  = r_out_irq;

    `DTR_ASSERT_NEXT(a_div_prescale_nonzero, i_cmd.accept && (w_cmd == dtr_pkg::CMD_ADVANCE), r_dpre != 9'd0, "divider prescaler zero after advance")
    `DTR_ASSERT_NOW(a_timer_prescale_range, 1'b1, CW'(r_tpre) <= CW'(P0), "timer prescaler above longest period")

endmodule

// ----- hdl/dtr_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtr_ctrl
// Request sequencer: accepts items, runs the timer step loop, owns result valid.
// ----------------------------------------------------------------------------
module dtr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  dtr_pkg::t_dp_status   i_status,
    output dtr_pkg::t_ctrl_cmd    o_cmd
);

    `include "divider_timer_with_reload_top_macros.svh"

    dtr_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_out_free;
    logic            w_accept;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && (r_state == dtr_pkg::ST_IDLE) && w_out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dtr_pkg::ST_IDLE: begin
                if (w_accept && i_status.adv_loop) begin
                    n_state = dtr_pkg::ST_STEP;
                end
            end
            dtr_pkg::ST_STEP: begin
                if (i_status.step_last) begin
                    n_state = w_out_free ? dtr_pkg::ST_IDLE : dtr_pkg::ST_HOLD;
                end
            end
            dtr_pkg::ST_HOLD: begin
                if (w_out_free) begin
                    n_state = dtr_pkg::ST_IDLE;
                end
            end
            default: n_state = dtr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready      = (r_state == dtr_pkg::ST_IDLE) && w_out_free;
        o_cmd.accept    = w_accept;
        o_cmd.load_acc  = w_accept && !i_status.adv_loop;
        o_cmd.step      = (r_state == dtr_pkg::ST_STEP);
        o_cmd.load_step = ((r_state == dtr_pkg::ST_STEP) && i_status.step_last && w_out_free)
                        || ((r_state == dtr_pkg::ST_HOLD) && w_out_free);
        if (o_cmd.load_acc || o_cmd.load_step) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    `DTR_ASSERT_NOW(a_hold_has_result, r_state == dtr_pkg::ST_HOLD, r_out_valid, "hold state without pending result")
    `DTR_ASSERT_NEXT(a_short_item_result, w_accept && !i_status.adv_loop, r_out_valid && (r_state == dtr_pkg::ST_IDLE), "short request gave no result")
    `DTR_ASSERT_NEXT(a_loop_entry, w_accept && i_status.adv_loop, r_state == dtr_pkg::ST_STEP, "timer loop not entered")

endmodule

// ----- hdl/divider_timer_with_reload_top.sv -----
// ----------------------------------------------------------------------------
// divider_timer_with_reload_top
// Divider and timer with modulo reload behind a request/result stream.
// ----------------------------------------------------------------------------
// Each request returns one result. Register writes, reads and advances with
// the timer stopped or zero cycles finish on accept, with the result
// registered. An advance with the timer started steps through the timer
// prescaler periods in a single step unit, which reloads and bumps the timer
// count once per cycle until the advanced cycles are used up. A finished result
// sits in an output register, so a new request is taken while it waits as
// long as the result side takes it in the same cycle.
module divider_timer_with_reload_top #(
    parameter int unsigned CPU_CLOCK_HZ = 4194304
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // command[1:0], reg_offset[3:2], write_data[11:4], cycles[19:12], zero pad
    input  logic [dtr_pkg::IN_W-1:0]    i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // read_data[7:0], timer_interrupt[8], zero pad
    output logic [dtr_pkg::OUT_W-1:0]   o_m_tdata
);

    dtr_pkg::t_ctrl_cmd  w_cmd;
    dtr_pkg::t_dp_status w_status;
    logic [7:0]          w_read_data;
    logic                w_timer_interrupt;

    dtr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dtr_dpath #(
        .CPU_CLOCK_HZ (CPU_CLOCK_HZ)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_command         (i_s_tdata[1:0]),
        .i_reg_offset      (i_s_tdata[3:2]),
        .i_write_data      (i_s_tdata[11:4]),
        .i_cycles          (i_s_tdata[19:12]),
        .o_status          (w_status),
        .o_read_data       (w_read_data),
        .o_timer_interrupt (w_timer_interrupt)
    );

    assign o_m_tdata = {7'd0, w_timer_interrupt, w_read_data};

endmodule
